@@ hw/rtl/opstk_pkg.sv @@
// Shared types and constants of the operand stack: opcodes, status codes
// and the packing of the request and response tdata words.
// No dependencies.
package opstk_pkg;

   localparam int OPCODE_W   = 4;
   localparam int PUSH_W     = 64;
   localparam int POSITION_W = 9;
   localparam int RESULT_W   = 64;
   localparam int DEPTH_W    = 9;
   localparam int STATUS_W   = 2;
   localparam int FRAME_W    = 8;

   localparam int REQ_FIELDS_W = OPCODE_W + PUSH_W + POSITION_W;
   localparam int RSP_FIELDS_W = RESULT_W + DEPTH_W + STATUS_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_TDATA_W - RSP_FIELDS_W;

   typedef enum logic [OPCODE_W-1:0] {
      OP_PUSH      = 4'd0,
      OP_POP       = 4'd1,
      OP_DUP       = 4'd2,
      OP_SWAP      = 4'd3,
      OP_LOAD      = 4'd4,
      OP_STORE     = 4'd5,
      OP_READ      = 4'd6,
      OP_SET_SIZE  = 4'd7,
      OP_SET_FRAME = 4'd8,
      OP_CLEAR     = 4'd9
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_UNDER = 2'd1,
      ST_OVER  = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

endpackage

@@ hw/rtl/operand_stack_with_frame_access.sv @@
// Operand stack with frame-relative load and store. One request at a time:
// the request is taken in the idle cycle, decoded, then stepped through the
// single stack RAM (one read and one write port). Set size, set frame, clear,
// push, unused opcodes and any error found at decode go from S_DECODE straight
// to S_OUT; pop, dup, read and a load or store whose frame address is out of
// range pass through S_RD1; load and store through S_RD1 and S_RD2; swap
// through S_RD1, S_RD2 and S_WR, as each RAM read adds a state and swap adds
// a second write. A response waiting on rsp_tready holds the next one.
// Depends on opstk_pkg and opstk_ram.
module operand_stack_with_frame_access #(
   parameter int STACK_DEPTH = 256,
   parameter int VALUE_WIDTH = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // opcode[3:0], push_value[67:4], position[76:68], zero pad
   input  logic [opstk_pkg::REQ_TDATA_W-1:0]  req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // result_value[63:0], stack_depth[72:64], status[74:73], zero pad
   output logic [opstk_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   localparam int AW   = $clog2(STACK_DEPTH);
   localparam int SW   = $clog2(STACK_DEPTH + 1);
   localparam int CW   = (SW > opstk_pkg::POSITION_W) ? SW : opstk_pkg::POSITION_W;
   localparam int SUMW = VALUE_WIDTH + 2;
   localparam int XW   = (SUMW > SW) ? SUMW : SW;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_RD1,
      S_RD2,
      S_WR,
      S_OUT
   } state_type;

   state_type                            state_ff, state_in;
   opstk_pkg::opcode_type                op_ff, op_in;
   logic [VALUE_WIDTH-1:0]               pv_ff, pv_in;
   logic [opstk_pkg::POSITION_W-1:0]     pos_ff, pos_in;
   logic [VALUE_WIDTH-1:0]               tmp_ff, tmp_in;
   logic [AW-1:0]                        addr_ff, addr_in;
   logic [SW-1:0]                        size_ff, size_in;
   logic [opstk_pkg::FRAME_W-1:0]        frame_ff, frame_in;
   logic [VALUE_WIDTH-1:0]               res_ff, res_in;
   opstk_pkg::status_type                status_ff, status_in;
   logic                                 rsp_tvalid_ff, rsp_tvalid_in;
   logic [opstk_pkg::RSP_TDATA_W-1:0]    rsp_tdata_ff, rsp_tdata_in;

   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [VALUE_WIDTH-1:0] wr_data;
   logic [AW-1:0]          rd_addr;
   logic [VALUE_WIDTH-1:0] rd_data;

   logic [AW-1:0]   top_addr, sub_addr, push_addr;
   logic [CW-1:0]   pos_x, size_x;
   logic            size_full;
   logic [SW-1:0]   fa_n;
   logic [SUMW-1:0] fa_sum;
   logic [XW-1:0]   fa_sum_x;
   logic            fa_ok;
   logic [AW-1:0]   fa_addr;

   opstk_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (STACK_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   assign top_addr  = AW'(size_ff - SW'(1));
   assign sub_addr  = AW'(size_ff - SW'(2));
   assign push_addr = AW'(size_ff);
   assign pos_x     = CW'(pos_ff);
   assign size_x    = CW'(size_ff);
   assign size_full = (size_ff == SW'(STACK_DEPTH));

   // frame address unit: base + signed offset, checked against remaining count
   assign fa_n     = (op_ff == opstk_pkg::OP_LOAD) ? SW'(size_ff - SW'(1))
                                                   : SW'(size_ff - SW'(2));
   assign fa_sum   = SUMW'($signed(rd_data)) + SUMW'(frame_ff);
   assign fa_sum_x = XW'(fa_sum);
   assign fa_ok    = !fa_sum[SUMW-1] && (fa_sum_x < XW'(fa_n));
   assign fa_addr  = fa_sum_x[AW-1:0];

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      pv_in         = pv_ff;
      pos_in        = pos_ff;
      tmp_in        = tmp_ff;
      addr_in       = addr_ff;
      size_in       = size_ff;
      frame_in      = frame_ff;
      res_in        = res_ff;
      status_in     = status_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      wr_en         = 1'b0;
      wr_addr       = top_addr;
      wr_data       = rd_data;
      rd_addr       = top_addr;

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in    = opstk_pkg::opcode_type'(req_tdata[opstk_pkg::OPCODE_W-1:0]);
               pv_in    = req_tdata[opstk_pkg::OPCODE_W +: VALUE_WIDTH];
               pos_in   = req_tdata[opstk_pkg::OPCODE_W + opstk_pkg::PUSH_W +:
                                    opstk_pkg::POSITION_W];
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            res_in    = '0;
            status_in = opstk_pkg::ST_OK;
            state_in  = S_OUT;
            case (op_ff)
               opstk_pkg::OP_PUSH: begin
                  if (size_full) begin
                     status_in = opstk_pkg::ST_OVER;
                  end else begin
                     wr_en   = 1'b1;
                     wr_addr = push_addr;
                     wr_data = pv_ff;
                     size_in = size_ff + SW'(1);
                  end
               end
               opstk_pkg::OP_POP, opstk_pkg::OP_LOAD: begin
                  if (size_ff == '0) begin
                     status_in = opstk_pkg::ST_UNDER;
                  end else begin
                     state_in = S_RD1;
                  end
               end
               opstk_pkg::OP_DUP: begin
                  if (size_ff == '0) begin
                     status_in = opstk_pkg::ST_UNDER;
                  end else if (size_full) begin
                     status_in = opstk_pkg::ST_OVER;
                  end else begin
                     state_in = S_RD1;
                  end
               end
               opstk_pkg::OP_SWAP: begin
                  if (size_ff < SW'(2)) begin
                     status_in = opstk_pkg::ST_UNDER;
                  end else begin
                     state_in = S_RD1;
                  end
               end
               opstk_pkg::OP_STORE: begin
                  rd_addr = sub_addr;
                  if (size_ff < SW'(2)) begin
                     status_in = opstk_pkg::ST_UNDER;
                  end else begin
                     state_in = S_RD1;
                  end
               end
               opstk_pkg::OP_READ: begin
                  rd_addr = pos_x[AW-1:0];
                  if (pos_x >= size_x) begin
                     status_in = opstk_pkg::ST_RANGE;
                  end else begin
                     state_in = S_RD1;
                  end
               end
               opstk_pkg::OP_SET_SIZE: begin
                  if (pos_x > size_x) begin
                     status_in = opstk_pkg::ST_RANGE;
                  end else begin
                     size_in = SW'(pos_x);
                  end
               end
               opstk_pkg::OP_SET_FRAME: begin
                  if (pos_ff[opstk_pkg::POSITION_W-1]) begin
                     status_in = opstk_pkg::ST_RANGE;
                  end else begin
                     frame_in = pos_ff[opstk_pkg::FRAME_W-1:0];
                  end
               end
               opstk_pkg::OP_CLEAR: begin
                  size_in = '0;
               end
               default: begin
               end
            endcase
         end
         S_RD1: begin
            state_in = S_OUT;
            case (op_ff)
               opstk_pkg::OP_POP: begin
                  res_in  = rd_data;
                  size_in = size_ff - SW'(1);
               end
               opstk_pkg::OP_READ: begin
                  res_in = rd_data;
               end
               opstk_pkg::OP_DUP: begin
                  wr_en   = 1'b1;
                  wr_addr = push_addr;
                  size_in = size_ff + SW'(1);
               end
               opstk_pkg::OP_SWAP: begin
                  tmp_in   = rd_data;
                  rd_addr  = sub_addr;
                  state_in = S_RD2;
               end
               opstk_pkg::OP_LOAD: begin
                  rd_addr = fa_addr;
                  if (fa_ok) begin
                     state_in = S_RD2;
                  end else begin
                     status_in = opstk_pkg::ST_RANGE;
                  end
               end
               opstk_pkg::OP_STORE: begin
                  addr_in = fa_addr;
                  if (fa_ok) begin
                     state_in = S_RD2;
                  end else begin
                     status_in = opstk_pkg::ST_RANGE;
                  end
               end
               default: begin
               end
            endcase
         end
         S_RD2: begin
            state_in = S_OUT;
            case (op_ff)
               opstk_pkg::OP_SWAP: begin
                  wr_en    = 1'b1;
                  state_in = S_WR;
               end
               opstk_pkg::OP_LOAD: begin
                  wr_en  = 1'b1;
                  res_in = rd_data;
               end
               opstk_pkg::OP_STORE: begin
                  wr_en   = 1'b1;
                  wr_addr = addr_ff;
                  size_in = size_ff - SW'(2);
               end
               default: begin
               end
            endcase
         end
         S_WR: begin
            wr_en    = 1'b1;
            wr_addr  = sub_addr;
            wr_data  = tmp_ff;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {{opstk_pkg::RSP_PAD_W{1'b0}}, status_ff,
                                opstk_pkg::DEPTH_W'(size_ff),
                                opstk_pkg::RESULT_W'($signed(res_ff))};
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         size_ff       <= '0;
         frame_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         size_ff       <= size_in;
         frame_ff      <= frame_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      op_ff        <= op_in;
      pv_ff        <= pv_in;
      pos_ff       <= pos_in;
      tmp_ff       <= tmp_in;
      addr_ff      <= addr_in;
      res_ff       <= res_in;
      status_ff    <= status_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

endmodule

@@ hw/rtl/opstk_ram.sv @@
// Generic single-clock RAM, one write port and one read port with
// registered read data. No dependencies.
module opstk_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
